// ===== hdl/sia_pkg.sv =====
`timescale 1ns / 1ps

package sia_pkg;

  // coordinate width; the fraction point cancels in every formula
  localparam int CW    = 16;
  localparam int DW    = CW + 1;        // coordinate difference
  localparam int PW    = 2 * DW;        // product of two differences
  localparam int PW3   = 3 * DW;        // product of three terms
  localparam int DEN_W = PW + 1;        // cross product denominator
  localparam int NUM_W = 3 * DW + 2;    // crossing numerator
  localparam int QW    = CW + 1;        // quotient magnitude bits
  localparam int REM_W = DEN_W + QW;    // divider partial remainder
  localparam int VW    = CW + 3;        // candidate point coordinate

  typedef enum logic [2:0] {
    K_NONE,   // both vertical
    K_GEN,    // neither vertical, lines cross
    K_AV,     // only first segment vertical
    K_BV,     // only second segment vertical
    K_PAR     // neither vertical, parallel
  } kind_t;

  typedef struct packed {
    logic signed [CW-1:0] ax0;
    logic signed [CW-1:0] ay0;
    logic signed [CW-1:0] ax1;
    logic signed [CW-1:0] ay1;
    logic signed [CW-1:0] bx0;
    logic signed [CW-1:0] by0;
    logic signed [CW-1:0] bx1;
    logic signed [CW-1:0] by1;
  } seg_t;

endpackage

// ===== hdl/sia_div.sv =====
`timescale 1ns / 1ps

module sia_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [sia_pkg::NUM_W-1:0] num,
  input  logic signed [sia_pkg::DEN_W-1:0] den,
  output logic signed [sia_pkg::QW:0]      quo,
  output logic                             ovf
);
  import sia_pkg::*;

  // restoring divider, one quotient bit per stage, truncating toward zero
  logic [REM_W-1:0] rem_r [0:QW];
  logic [DEN_W-1:0] dv_r  [0:QW];
  logic [QW-1:0]    q_r   [0:QW];
  logic             neg_r [0:QW];
  logic             ovf_r [0:QW];

  logic [NUM_W-1:0] nmag;
  logic [DEN_W-1:0] dmag;
  logic [NUM_W-1:0] dlim;
  logic [QW:0]      qm;

  assign nmag = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign dmag = den[DEN_W-1] ? (~den + 1'b1) : den;
  assign dlim = NUM_W'({dmag, {QW{1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= nmag[REM_W-1:0];
      dv_r[0]  <= dmag;
      q_r[0]   <= '0;
      neg_r[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      ovf_r[0] <= (nmag >= dlim);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [REM_W-1:0] sh;
    logic [REM_W:0]   diff;

    assign sh   = REM_W'(dv_r[k]) << B;
    assign diff = {1'b0, rem_r[k]} - {1'b0, sh};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1]  <= dv_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
        if (!diff[REM_W]) begin
          rem_r[k+1] <= diff[REM_W-1:0];
          q_r[k+1]   <= q_r[k] | (QW'(1) << B);
        end else begin
          rem_r[k+1] <= rem_r[k];
          q_r[k+1]   <= q_r[k];
        end
      end
    end
  end

  assign qm  = {1'b0, q_r[QW]};
  assign quo = $signed(neg_r[QW] ? (~qm + 1'b1) : qm);
  assign ovf = ovf_r[QW];

endmodule

// ===== hdl/segment_intersection_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_ax0 .. in_by1, two segments
// out_      output     out_valid / out_stall out_hit, out_point_valid,
//                                           out_cross_x, out_cross_y
//
// one item per cycle sustained while the output is not stalled; each item
// passes through the two pipelined restoring dividers, one quotient bit
// per stage
// synchronous active-low reset clears only the valid bits of every stage
// a stalled output freezes the whole pipeline; in_stall follows out_stall
// only while the output register holds an item

module segment_intersection_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [sia_pkg::CW-1:0] in_ax0,
  input  logic signed [sia_pkg::CW-1:0] in_ay0,
  input  logic signed [sia_pkg::CW-1:0] in_ax1,
  input  logic signed [sia_pkg::CW-1:0] in_ay1,
  input  logic signed [sia_pkg::CW-1:0] in_bx0,
  input  logic signed [sia_pkg::CW-1:0] in_by0,
  input  logic signed [sia_pkg::CW-1:0] in_bx1,
  input  logic signed [sia_pkg::CW-1:0] in_by1,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic                          out_point_valid,
  output logic signed [sia_pkg::CW-1:0] out_cross_x,
  output logic signed [sia_pkg::CW-1:0] out_cross_y
);
  import sia_pkg::*;

  // sideband that rides alongside a divider
  typedef struct packed {
    seg_t                 c;
    kind_t                kind;
    logic                 coll;
    logic                 xbad;
    logic signed [VW-1:0] x;
    logic signed [DW-1:0] dax;
    logic signed [DW-1:0] day;
    logic signed [DW-1:0] dbx;
    logic signed [DW-1:0] dby;
  } sb_t;

  // strictly inside a box
  function automatic logic in_open(
    input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
    input logic signed [CW-1:0] x0, input logic signed [CW-1:0] y0,
    input logic signed [CW-1:0] x1, input logic signed [CW-1:0] y1);
    return (x > x0 || x > x1) && (x < x0 || x < x1) &&
           (y > y0 || y > y1) && (y < y0 || y < y1);
  endfunction

  // v within the closed span of a and b
  function automatic logic in_span(input logic signed [VW-1:0] v,
                                   input logic signed [CW-1:0] a,
                                   input logic signed [CW-1:0] b);
    logic signed [VW-1:0] ae;
    logic signed [VW-1:0] be;
    ae = VW'(a);
    be = VW'(b);
    return (v >= ae || v >= be) && (v <= ae || v <= be);
  endfunction

  // global advance: the pipeline moves unless a finished item is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: capture and differences
  logic                 v1_r;
  seg_t                 c1_r;
  logic signed [DW-1:0] dax1_r, day1_r, dbx1_r, dby1_r, ey1_r, ex1_r;

  // stage 2: first products
  logic                 v2_r;
  seg_t                 c2_r;
  logic signed [DW-1:0] dax2_r, day2_r, dbx2_r, dby2_r;
  logic signed [PW-1:0] p_yb2_r, p_ba2_r, p_ea2_r, p_xa2_r;

  // stage 3: denominator, side test, triple products
  logic                    v3_r;
  seg_t                    c3_r;
  logic signed [DW-1:0]    dax3_r, day3_r, dbx3_r, dby3_r;
  logic signed [DEN_W-1:0] den3_r;
  logic                    side0_3_r;
  logic signed [PW3-1:0]   m1_3_r, m2_3_r, m3_3_r;

  // stage 4: numerator, case split, collinear overlap
  logic                    v4_r;
  sb_t                     s4_r;
  logic signed [NUM_W-1:0] num4_r;
  logic signed [DEN_W-1:0] den4_r;

  kind_t kind4_nxt;
  logic  coll4_nxt;

  always_comb begin
    priority if (dax3_r == '0 && dbx3_r == '0) kind4_nxt = K_NONE;
    else if (dax3_r == '0) kind4_nxt = K_AV;
    else if (dbx3_r == '0) kind4_nxt = K_BV;
    else if (den3_r == '0) kind4_nxt = K_PAR;
    else kind4_nxt = K_GEN;
  end

  assign coll4_nxt = side0_3_r &&
    (in_open(c3_r.bx0, c3_r.by0, c3_r.ax0, c3_r.ay0, c3_r.ax1, c3_r.ay1) ||
     in_open(c3_r.bx1, c3_r.by1, c3_r.ax0, c3_r.ay0, c3_r.ax1, c3_r.ay1) ||
     in_open(c3_r.ax0, c3_r.ay0, c3_r.bx0, c3_r.by0, c3_r.bx1, c3_r.by1) ||
     in_open(c3_r.ax1, c3_r.ay1, c3_r.bx0, c3_r.by0, c3_r.bx1, c3_r.by1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= '{in_ax0, in_ay0, in_ax1, in_ay1, in_bx0, in_by0, in_bx1, in_by1};
      dax1_r <= DW'(in_ax1) - DW'(in_ax0);
      day1_r <= DW'(in_ay1) - DW'(in_ay0);
      dbx1_r <= DW'(in_bx1) - DW'(in_bx0);
      dby1_r <= DW'(in_by1) - DW'(in_by0);
      ey1_r  <= DW'(in_by0) - DW'(in_ay0);
      ex1_r  <= DW'(in_bx0) - DW'(in_ax0);

      c2_r    <= c1_r;
      dax2_r  <= dax1_r;
      day2_r  <= day1_r;
      dbx2_r  <= dbx1_r;
      dby2_r  <= dby1_r;
      p_yb2_r <= day1_r * dbx1_r;
      p_ba2_r <= dby1_r * dax1_r;
      p_ea2_r <= ey1_r * dax1_r;
      p_xa2_r <= ex1_r * day1_r;

      c3_r      <= c2_r;
      dax3_r    <= dax2_r;
      day3_r    <= day2_r;
      dbx3_r    <= dbx2_r;
      dby3_r    <= dby2_r;
      den3_r    <= DEN_W'(p_yb2_r) - DEN_W'(p_ba2_r);
      side0_3_r <= (p_xa2_r == p_ea2_r);
      m1_3_r    <= p_ea2_r * PW3'(dbx2_r);
      m2_3_r    <= p_yb2_r * PW3'(c2_r.ax0);
      m3_3_r    <= p_ba2_r * PW3'(c2_r.bx0);

      s4_r.c    <= c3_r;
      s4_r.kind <= kind4_nxt;
      s4_r.coll <= coll4_nxt && (kind4_nxt == K_PAR);
      s4_r.xbad <= 1'b0;
      s4_r.x    <= '0;
      s4_r.dax  <= dax3_r;
      s4_r.day  <= day3_r;
      s4_r.dbx  <= dbx3_r;
      s4_r.dby  <= dby3_r;
      num4_r    <= NUM_W'(m1_3_r) + NUM_W'(m2_3_r) - NUM_W'(m3_3_r);
      den4_r    <= den3_r;
    end
  end

  // crossing x divider with its sideband line
  logic signed [QW:0] quo1;
  logic               ovf1;
  logic               vl1_r [0:QW];
  sb_t                sl1_r [0:QW];

  sia_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (num4_r),
    .den (den4_r),
    .quo (quo1),
    .ovf (ovf1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) vl1_r[k] <= 1'b0;
    end else if (en) begin
      vl1_r[0] <= v4_r;
      for (int k = 0; k < QW; k++) vl1_r[k+1] <= vl1_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl1_r[0] <= s4_r;
      for (int k = 0; k < QW; k++) sl1_r[k+1] <= sl1_r[k];
    end
  end

  // stage X: pick x, check it against both x spans, form the y offset
  sb_t                  sx_nxt;
  logic signed [VW-1:0] tx_nxt;
  logic                 vx_r;
  sb_t                  sx_r;
  logic signed [VW-1:0] tx_r;

  always_comb begin
    sx_nxt = sl1_r[QW];
    unique case (sl1_r[QW].kind)
      K_GEN:   sx_nxt.x = VW'(quo1);
      K_AV:    sx_nxt.x = VW'(sl1_r[QW].c.ax0);
      default: sx_nxt.x = VW'(sl1_r[QW].c.bx0);
    endcase
    sx_nxt.xbad = ((sl1_r[QW].kind == K_GEN) && ovf1) ||
                  !in_span(sx_nxt.x, sl1_r[QW].c.ax0, sl1_r[QW].c.ax1) ||
                  !in_span(sx_nxt.x, sl1_r[QW].c.bx0, sl1_r[QW].c.bx1);
    // only first vertical: y runs along the second segment
    if (sl1_r[QW].kind == K_AV) tx_nxt = sx_nxt.x - VW'(sl1_r[QW].c.bx0);
    else tx_nxt = sx_nxt.x - VW'(sl1_r[QW].c.ax0);
  end

  // stage M: y numerator and divisor
  localparam int N2W = DW + VW;
  logic                    vm_r;
  sb_t                     sm_r;
  logic signed [N2W-1:0]   n2_r;
  logic signed [DW-1:0]    d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= 1'b0;
      vm_r <= 1'b0;
    end else if (en) begin
      vx_r <= vl1_r[QW];
      vm_r <= vx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= sx_nxt;
      tx_r <= tx_nxt;
      sm_r <= sx_r;
      if (sx_r.kind == K_AV) begin
        n2_r <= N2W'(sx_r.dby) * tx_r;
        d2_r <= sx_r.dbx;
      end else begin
        n2_r <= N2W'(sx_r.day) * tx_r;
        d2_r <= sx_r.dax;
      end
    end
  end

  // crossing y divider with its sideband line
  logic signed [QW:0] quo2;
  logic               ovf2;
  logic               vl2_r [0:QW];
  sb_t                sl2_r [0:QW];

  sia_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (NUM_W'(n2_r)),
    .den (DEN_W'(d2_r)),
    .quo (quo2),
    .ovf (ovf2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) vl2_r[k] <= 1'b0;
    end else if (en) begin
      vl2_r[0] <= vm_r;
      for (int k = 0; k < QW; k++) vl2_r[k+1] <= vl2_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl2_r[0] <= sm_r;
      for (int k = 0; k < QW; k++) sl2_r[k+1] <= sl2_r[k];
    end
  end

  // final stage: add the base, check y spans, build the result item
  sb_t                  sy;
  logic signed [VW-1:0] y_nxt;
  logic                 ybad;
  logic                 pt_nxt;
  logic                 out_valid_r, out_hit_r, out_point_valid_r;
  logic signed [CW-1:0] out_cross_x_r, out_cross_y_r;

  assign sy = sl2_r[QW];

  always_comb begin
    if (sy.kind == K_AV) y_nxt = VW'(quo2) + VW'(sy.c.by0);
    else y_nxt = VW'(quo2) + VW'(sy.c.ay0);
    ybad   = ovf2 || !in_span(y_nxt, sy.c.ay0, sy.c.ay1) ||
             !in_span(y_nxt, sy.c.by0, sy.c.by1);
    pt_nxt = (sy.kind == K_GEN || sy.kind == K_AV || sy.kind == K_BV) &&
             !sy.xbad && !ybad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vl2_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r         <= pt_nxt || sy.coll;
      out_point_valid_r <= pt_nxt;
      out_cross_x_r     <= pt_nxt ? sy.x[CW-1:0] : '0;
      out_cross_y_r     <= pt_nxt ? y_nxt[CW-1:0] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_point_valid = out_point_valid_r;
  assign out_cross_x     = out_cross_x_r;
  assign out_cross_y     = out_cross_y_r;

endmodule

// ===== dv/segment_intersection_unit_test.sv =====
`timescale 1ns / 1ps

module segment_intersection_unit_test;
  import sia_pkg::*;

  // one pair of segments as offered on the input channel
  typedef struct {
    logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  // one intersection verdict as seen on the output channel
  typedef struct {
    logic                 hit;
    logic                 pv;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } verdict_t;

  localparam int PIPE_DEPTH = 2 * (CW + 2) + 7;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 300;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_ax0, in_ay0, in_ax1, in_ay1;
  logic signed [CW-1:0] in_bx0, in_by0, in_bx1, in_by1;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic out_point_valid;
  logic signed [CW-1:0] out_cross_x, out_cross_y;

  segment_intersection_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ax0(in_ax0), .in_ay0(in_ay0), .in_ax1(in_ax1), .in_ay1(in_ay1),
    .in_bx0(in_bx0), .in_by0(in_by0), .in_bx1(in_bx1), .in_by1(in_by1),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_point_valid(out_point_valid),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  seg_pair_t pending_pairs[$];
  verdict_t  expected_verdicts[$];
  int        mismatch_count;
  bit        stimulus_done;
  bit        hold_request;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // truncating division on 64-bit values, divisor nonzero
  function automatic longint div_trunc(longint n, longint d);
    longint q;
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic bit open_box(longint x, longint y, longint x0, longint y0,
                                  longint x1, longint y1);
    return x > (x0 < x1 ? x0 : x1) && x < (x0 > x1 ? x0 : x1) &&
           y > (y0 < y1 ? y0 : y1) && y < (y0 > y1 ? y0 : y1);
  endfunction

  function automatic bit closed_box(longint x, longint y, longint x0, longint y0,
                                    longint x1, longint y1);
    return x >= (x0 < x1 ? x0 : x1) && x <= (x0 > x1 ? x0 : x1) &&
           y >= (y0 < y1 ? y0 : y1) && y <= (y0 > y1 ? y0 : y1);
  endfunction

  // expected verdict for one pair; 16-bit inputs keep every product exact in 64 bits
  function automatic verdict_t intersect_segments(seg_pair_t p);
    verdict_t v;
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dax, day, dbx, dby, den, num, side, x, y;
    bit have;
    ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
    bx0 = p.bx0; by0 = p.by0; bx1 = p.bx1; by1 = p.by1;
    dax = ax1 - ax0; day = ay1 - ay0;
    dbx = bx1 - bx0; dby = by1 - by0;
    x = 0; y = 0; have = 0;
    v.hit = 0;
    if (dax != 0 && dbx != 0) begin
      den = day * dbx - dby * dax;
      if (den == 0) begin
        // parallel: collinear overlap needs an endpoint strictly inside
        side = (bx0 - ax0) * day - (by0 - ay0) * dax;
        if (side == 0)
          v.hit = open_box(bx0, by0, ax0, ay0, ax1, ay1) ||
                  open_box(bx1, by1, ax0, ay0, ax1, ay1) ||
                  open_box(ax0, ay0, bx0, by0, bx1, by1) ||
                  open_box(ax1, ay1, bx0, by0, bx1, by1);
      end else begin
        num = (by0 - ay0) * dax * dbx + day * dbx * ax0 - dby * dax * bx0;
        x = div_trunc(num, den);
        y = div_trunc(day * (x - ax0), dax) + ay0;
        have = 1;
      end
    end else if (dax == 0 && dbx != 0) begin
      x = ax0;
      y = div_trunc(dby * (ax0 - bx0), dbx) + by0;
      have = 1;
    end else if (dax != 0 && dbx == 0) begin
      x = bx0;
      y = div_trunc(day * (bx0 - ax0), dax) + ay0;
      have = 1;
    end
    if (have) begin
      have = closed_box(x, y, ax0, ay0, ax1, ay1) && closed_box(x, y, bx0, by0, bx1, by1);
      v.hit = have;
    end
    v.pv = have;
    v.cx = have ? x[CW-1:0] : '0;
    v.cy = have ? y[CW-1:0] : '0;
    return v;
  endfunction

  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.ax0 = CW'(ax0); p.ay0 = CW'(ay0); p.ax1 = CW'(ax1); p.ay1 = CW'(ay1);
    p.bx0 = CW'(bx0); p.by0 = CW'(by0); p.bx1 = CW'(bx1); p.by1 = CW'(by1);
    return p;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int span);
    if (span == 0) return CW'($urandom);
    return CW'(int'($urandom_range(2 * span)) - span);
  endfunction

  // random pair: wild values, crossing pairs, single verticals, parallel offsets or collinear overlaps
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int span, kind, k;
    int dx, dy, sx, sy;
    span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(4, 14));
    p = make_pair(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                  rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
    kind = $urandom_range(9);
    if (kind == 0) p.ax1 = p.ax0;
    else if (kind == 1) p.bx1 = p.bx0;
    else if (kind == 2) begin
      // b along the same line as a, scaled by small steps
      k = $urandom_range(1, 4);
      p.ax0 = rand_coord(1000); p.ay0 = rand_coord(1000);
      dx = 4 * k * (($urandom_range(1) != 0) ? 3 : -3);
      dy = 4 * k * (int'($urandom_range(2)) - 1);
      p.ax1 = CW'(int'(p.ax0) + dx);
      p.ay1 = CW'(int'(p.ay0) + dy);
      sx = int'(p.ax0) + dx / 2 * int'($urandom_range(3));
      sy = int'(p.ay0) + dy / 2 * int'($urandom_range(3));
      p.bx0 = CW'(sx);
      p.by0 = CW'(sy);
      p.bx1 = CW'(sx + dx / 4 * (int'($urandom_range(4)) - 2));
      p.by1 = CW'(sy + dy / 4 * (int'($urandom_range(4)) - 2));
    end else if (kind == 3) begin
      // parallel offset
      p.bx1 = p.bx0 + (p.ax1 - p.ax0) / 2;
      p.by1 = p.by0 + (p.ay1 - p.ay0) / 2;
    end else if (kind < 7) begin
      // b crosses over a around a common center
      p.bx0 = -p.ax0; p.by0 = -p.ay1; p.bx1 = -p.ax1; p.by1 = -p.ay0;
      p.ax0 = p.ax0 / 2; p.ax1 = -p.ax0 + rand_coord(8);
    end
    return p;
  endfunction

  initial begin
    seg_pair_t p;
    int mx, mn;
    mx = 32767; mn = -32768;
    // corner cases first
    pending_pairs.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
    pending_pairs.push_back(make_pair(mx, mn, mn, mx, mx, mx, mn, mn));
    pending_pairs.push_back(make_pair(0, 0, 0, 100, 0, 0, 0, 50));       // both vertical
    pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 10, 10));        // point on segment
    pending_pairs.push_back(make_pair(0, -50, 0, 50, -40, 10, 40, -10)); // a vertical
    pending_pairs.push_back(make_pair(-40, 10, 40, -10, 7, -50, 7, 50)); // b vertical
    pending_pairs.push_back(make_pair(0, 0, 100, 0, 0, 10, 100, 10));    // parallel
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 50, 50, 150, 150));// collinear overlap
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 100, 100, 150, 150));// touching ends
    pending_pairs.push_back(make_pair(0, 0, 100, 0, 50, 0, 150, 0));     // horizontal collinear
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 20, 0, 30, -10));    // lines cross outside
    pending_pairs.push_back(make_pair(mn, 0, mx, 1, 0, mn, 1, mx));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(make_pair(mx, mx, mn, mn, mn, mn, mx, mx));
    pending_pairs.push_back(make_pair(-3, 7, 11, -5, -9, -2, 13, 4));
    pending_pairs.push_back(make_pair(mn, mn, mn, mx, mx, mn, mn, mx));
    repeat (1000) begin
      p = random_pair();
      pending_pairs.push_back(p);
    end
    stimulus_done = 1'b1;
  end

  // reset, then hand over to the driver and monitor
  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  // driver: one item from the queue at a time, random gap before each
  int send_gap;
  bit in_taken;
  initial begin
    in_valid = 1'b0;
    {in_ax0, in_ay0, in_ax1, in_ay1, in_bx0, in_by0, in_bx1, in_by1} = '0;
    send_gap = 0;
    in_taken = 1'b0;
  end

  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      // the item on the bus was taken at this edge
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        expected_verdicts.push_back(intersect_segments(pending_pairs.pop_front()));
        send_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(4);
        if ($urandom_range(7) == 0) send_gap = 0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (send_gap > 0 || pending_pairs.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap = send_gap - 1;
        end else begin
          in_valid <= 1'b1;
          in_ax0 <= pending_pairs[0].ax0; in_ay0 <= pending_pairs[0].ay0;
          in_ax1 <= pending_pairs[0].ax1; in_ay1 <= pending_pairs[0].ay1;
          in_bx0 <= pending_pairs[0].bx0; in_by0 <= pending_pairs[0].by0;
          in_bx1 <= pending_pairs[0].bx1; in_by1 <= pending_pairs[0].by1;
        end
      end
    end
  end

  // receiver: random stall per item, one long hold-off once traffic is flowing
  int stall_left;
  int hold_left;
  int verdicts_seen;
  initial begin
    out_stall = 1'b1;
    stall_left = 0;
    hold_left = 0;
    verdicts_seen = 0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (verdicts_seen == 200 && hold_left == 0 && !hold_request) begin
        hold_request = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'b1;
    end
  end

  // monitor: compare each taken result with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen = verdicts_seen + 1;
      stall_left = $urandom_range(1) ? 0 : $urandom_range(4);
      if (expected_verdicts.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) $display("result with nothing expected");
      end else begin
        want = expected_verdicts.pop_front();
        if (out_hit !== want.hit || out_point_valid !== want.pv ||
            out_cross_x !== want.cx || out_cross_y !== want.cy) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("mismatch: expected hit=%0d pv=%0d x=%0d y=%0d, got hit=%0d pv=%0d x=%0d y=%0d",
                     want.hit, want.pv, want.cx, want.cy,
                     out_hit, out_point_valid, out_cross_x, out_cross_y);
        end
      end
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    mismatch_count = 0;
    hold_request = 1'b0;
    idle_cycles = 0;
    @(posedge rst_n);
    fork
      begin
        wait (stimulus_done && pending_pairs.size() == 0 && !in_valid &&
              expected_verdicts.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
          $display("*** PASSED ***");
        else
          $display("*** FAILED ***");
        $finish;
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout waiting for results");
        $display("*** FAILED ***");
        $finish;
      end
    join
  end

endmodule
